/* hdl/rpnsc_pkg.sv */
// Shared widths, opcode and status codes for the RPN stack calculator.
package rpnsc_pkg;

    localparam int DATA_W = 32;
    localparam int OPC_W  = 3;
    localparam int STAT_W = 3;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OPC_W-1:0] OP_ADD  = 3'd1;
    localparam logic [OPC_W-1:0] OP_SUB  = 3'd2;
    localparam logic [OPC_W-1:0] OP_MUL  = 3'd3;
    localparam logic [OPC_W-1:0] OP_DIV  = 3'd4;
    localparam logic [OPC_W-1:0] OP_POP  = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FEW     = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

    // Value returned by a pop on an empty stack
    localparam logic [DATA_W-1:0] POP_EMPTY_VALUE = '1;

endpackage

/* hdl/rpnsc_divider.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module rpnsc_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [rpnsc_pkg::DATA_W-1:0] num,
    input  logic signed [rpnsc_pkg::DATA_W-1:0] den,
    output logic                              done,
    output logic        [rpnsc_pkg::DATA_W-1:0] quotient
);

    localparam int DW  = rpnsc_pkg::DATA_W;
    localparam int CNW = $clog2(DW);

    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [DW-1:0]  den_reg, den_next;
    logic           neg_reg, neg_next;

    logic [DW:0]    trial;
    logic [DW:0]    diff;

    // Restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num[DW-1] ? DW'(-num) : DW'(num);
            den_next  = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next  = num[DW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_next = diff[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? DW'(-quo_reg) : quo_reg;

endmodule

/* hdl/rpn_stack_calculator_top.sv */
// RPN stack calculator: stack in a synchronous RAM with a cached top entry.
// Flow after acceptance: push, pop on empty, undefined opcodes and operators short of
// operands go to S_FIN; pop, add/subtract/multiply and zero divisor pass S_EXEC first;
// divide passes S_EXEC and S_DIV (bit-serial divider). Items are taken one at a time;
// tready returns as the result loads; a full output register holds the sequencer longer.
// Reset: asynchronous, active low; clears count, sequencer and output valid, not the RAM.
module rpn_stack_calculator_top
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] operand
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [3:0]  m_axis_tuser    // [0] stack empty flag, [3:1] status
);

    localparam int DW = rpnsc_pkg::DATA_W;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0]
    {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [DW-1:0]                  tos_reg, tos_next;
    logic [rpnsc_pkg::OPC_W-1:0]    op_reg, op_next;
    logic [DW-1:0]                  res_value_reg, res_value_next;
    logic [rpnsc_pkg::STAT_W-1:0]   res_status_reg, res_status_next;
    logic                           m_valid_reg, m_valid_next;
    logic [DW-1:0]                  m_value_reg, m_value_next;
    logic                           m_empty_reg, m_empty_next;
    logic [rpnsc_pkg::STAT_W-1:0]   m_status_reg, m_status_next;

    // Stack RAM
    logic [DW-1:0]                  mem [STACK_DEPTH];
    logic [DW-1:0]                  rd_data_reg;
    logic                           mem_we;
    logic [AW-1:0]                  mem_waddr;
    logic [AW-1:0]                  mem_raddr;
    logic [DW-1:0]                  mem_wdata;

    // Operands and ALU
    logic                           in_xact;
    logic [CW-1:0]                  count_m1;
    logic [CW-1:0]                  count_m2;
    logic signed [DW-1:0]           opa;
    logic signed [DW-1:0]           opb;
    logic                           a_gt_b;
    logic [DW-1:0]                  prod;
    logic [DW-1:0]                  alu_res;
    logic signed [DW-1:0]           div_num;
    logic signed [DW-1:0]           div_den;
    logic                           div_start;
    logic                           div_done;
    logic [DW-1:0]                  div_quo;
    logic                           out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign count_m1      = count_reg - CW'(1);
    assign count_m2      = count_reg - CW'(2);

    // a is the entry below the top (from RAM), b is the cached top
    assign opa     = rd_data_reg;
    assign opb     = tos_reg;
    assign a_gt_b  = opa > opb;
    assign prod    = opa * opb;
    assign div_num = a_gt_b ? opa : opb;
    assign div_den = a_gt_b ? opb : opa;

    always_comb
    begin
        case (op_reg)
            rpnsc_pkg::OP_ADD: alu_res = opa + opb;
            rpnsc_pkg::OP_SUB: alu_res = a_gt_b ? (opa - opb) : (opb - opa);
            rpnsc_pkg::OP_MUL: alu_res = prod;
            default:           alu_res = div_quo;
        endcase
    end

    rpnsc_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_m2[AW-1:0];
        mem_raddr       = count_m2[AW-1:0];
        mem_wdata       = alu_res;
        div_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xact)
                begin
                    op_next         = s_axis_tuser;
                    res_status_next = rpnsc_pkg::ST_OK;
                    res_value_next  = (count_reg == '0) ? '0 : tos_reg;
                    state_next      = S_FIN;
                    case (s_axis_tuser)
                        rpnsc_pkg::OP_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                res_status_next = rpnsc_pkg::ST_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_waddr      = count_reg[AW-1:0];
                                mem_wdata      = s_axis_tdata;
                                count_next     = count_reg + CW'(1);
                                tos_next       = s_axis_tdata;
                                res_value_next = s_axis_tdata;
                            end
                        end
                        rpnsc_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_value_next  = rpnsc_pkg::POP_EMPTY_VALUE;
                                res_status_next = rpnsc_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res_value_next = tos_reg;
                                count_next     = count_m1;
                                state_next     = S_EXEC;
                            end
                        end
                        rpnsc_pkg::OP_ADD, rpnsc_pkg::OP_SUB,
                        rpnsc_pkg::OP_MUL, rpnsc_pkg::OP_DIV:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                res_status_next = rpnsc_pkg::ST_FEW;
                            end
                            else
                            begin
                                state_next = S_EXEC;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                state_next = S_FIN;
                case (op_reg)
                    rpnsc_pkg::OP_POP:
                    begin
                        // new top comes from RAM
                        tos_next = rd_data_reg;
                    end
                    rpnsc_pkg::OP_DIV:
                    begin
                        if (div_den == '0)
                        begin
                            res_status_next = rpnsc_pkg::ST_DIVZERO;
                            res_value_next  = tos_reg;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                        // add, subtract, multiply: write back over the lower entry
                        mem_we         = 1'b1;
                        count_next     = count_m1;
                        tos_next       = alu_res;
                        res_value_next = alu_res;
                    end
                endcase
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    mem_we         = 1'b1;
                    count_next     = count_m1;
                    tos_next       = alu_res;
                    res_value_next = alu_res;
                    state_next     = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_value_next  = m_value_reg;
        m_empty_next  = m_empty_reg;
        m_status_next = m_status_reg;
        if (state_reg == S_FIN && out_free)
        begin
            m_valid_next  = 1'b1;
            m_value_next  = res_value_reg;
            m_empty_next  = (count_reg == '0);
            m_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_empty_reg    <= m_empty_next;
        m_status_reg   <= m_status_next;
    end

    // Stack RAM, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_value_reg;
    assign m_axis_tuser  = {m_status_reg, m_empty_reg};

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide state");

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> m_axis_tvalid)
        else $error("finished result not loaded into output register");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xact && s_axis_tuser == rpnsc_pkg::OP_POP && count_reg == '0)
        |=> res_status_reg == rpnsc_pkg::ST_EMPTY)
        else $error("pop on empty stack not flagged");
`endif

endmodule

/* dv/tb_rpn_stack_calculator_top.sv */
// Self-checking stream testbench for the RPN stack calculator top level.
module tb_rpn_stack_calculator_top;

    localparam int STACK_DEPTH  = 64;
    localparam int N_RANDOM     = 1125;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;

    // Opcodes the block treats as no-ops
    localparam logic [rpnsc_pkg::OPC_W-1:0] OP_UNDEF6 = 3'd6;
    localparam logic [rpnsc_pkg::OPC_W-1:0] OP_UNDEF7 = 3'd7;

    // Random phase kinds
    localparam int MODE_MIXED = 0;
    localparam int MODE_FILL  = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        logic [rpnsc_pkg::DATA_W-1:0] value;
        logic                         empty_flag;
        logic [rpnsc_pkg::STAT_W-1:0] status;
    } calc_result_t;

    typedef struct {
        logic [rpnsc_pkg::OPC_W-1:0]  opcode;
        logic [rpnsc_pkg::DATA_W-1:0] operand;
        bit                           typed;
        calc_result_t                 want;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [2:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;
    logic [3:0]        m_axis_tuser;

    // Predictor state
    logic [rpnsc_pkg::DATA_W-1:0] calc_stack [STACK_DEPTH];
    int unsigned                  calc_depth = 0;

    calc_result_t      pending_results [$];
    dir_row_t          dir_rows [$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                stall_left = 0;
    bit                no_idle = 1'b0;

    rpn_stack_calculator_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Advance the stack model by one item and return the result it yields
    function automatic calc_result_t calc_step(logic [rpnsc_pkg::OPC_W-1:0] opc,
                                               logic [rpnsc_pkg::DATA_W-1:0] opnd);
        calc_result_t                 res;
        logic [rpnsc_pkg::DATA_W-1:0] ua;
        logic [rpnsc_pkg::DATA_W-1:0] ub;
        logic [rpnsc_pkg::DATA_W-1:0] r;
        longint                       num;
        longint                       den;
        longint                       quo;
        bit                           ok;
        res.status = rpnsc_pkg::ST_OK;
        res.value  = '0;
        r  = '0;
        ok = 1'b1;
        if (opc == rpnsc_pkg::OP_POP)
        begin
            if (calc_depth == 0)
            begin
                res.value  = rpnsc_pkg::POP_EMPTY_VALUE;
                res.status = rpnsc_pkg::ST_EMPTY;
            end
            else
            begin
                calc_depth--;
                res.value = calc_stack[calc_depth];
            end
        end
        else
        begin
            if (opc == rpnsc_pkg::OP_PUSH)
            begin
                if (calc_depth >= STACK_DEPTH)
                    res.status = rpnsc_pkg::ST_FULL;
                else
                begin
                    calc_stack[calc_depth] = opnd;
                    calc_depth++;
                end
            end
            else if (opc == rpnsc_pkg::OP_ADD || opc == rpnsc_pkg::OP_SUB
                     || opc == rpnsc_pkg::OP_MUL || opc == rpnsc_pkg::OP_DIV)
            begin
                if (calc_depth < 2)
                    res.status = rpnsc_pkg::ST_FEW;
                else
                begin
                    ua = calc_stack[calc_depth - 2];
                    ub = calc_stack[calc_depth - 1];
                    case (opc)
                        rpnsc_pkg::OP_ADD: r = ua + ub;
                        rpnsc_pkg::OP_SUB:
                            r = ($signed(ua) > $signed(ub)) ? ua - ub : ub - ua;
                        rpnsc_pkg::OP_MUL: r = ua * ub;
                        default:
                        begin
                            // larger value over the smaller one
                            num = ($signed(ua) > $signed(ub)) ? longint'($signed(ua))
                                                              : longint'($signed(ub));
                            den = ($signed(ua) > $signed(ub)) ? longint'($signed(ub))
                                                              : longint'($signed(ua));
                            if (den == 0)
                            begin
                                ok = 1'b0;
                                res.status = rpnsc_pkg::ST_DIVZERO;
                            end
                            else
                            begin
                                quo = num / den;
                                r = quo[rpnsc_pkg::DATA_W-1:0];
                            end
                        end
                    endcase
                    if (ok)
                    begin
                        calc_depth--;
                        calc_stack[calc_depth - 1] = r;
                    end
                end
            end
            res.value = (calc_depth == 0) ? '0 : calc_stack[calc_depth - 1];
        end
        res.empty_flag = (calc_depth == 0);
        return res;
    endfunction

    function automatic logic [rpnsc_pkg::DATA_W-1:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return ($urandom_range(0, 1) != 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            2: return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3, 4, 5: return $urandom_range(0, 40) - 20;
            default: return $urandom;
        endcase
    endfunction

    // Opcode mix per phase kind
    function automatic logic [rpnsc_pkg::OPC_W-1:0] pick_opcode(int mode);
        int r;
        int op_pick;
        int push_pct;
        int pop_pct;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                push_pct = 85;
                pop_pct  = 3;
            end
            MODE_DRAIN:
            begin
                push_pct = 10;
                pop_pct  = 25;
            end
            default:
            begin
                push_pct = 45;
                pop_pct  = 10;
            end
        endcase
        if (r < push_pct)
            return rpnsc_pkg::OP_PUSH;
        else if (r < push_pct + pop_pct)
            return rpnsc_pkg::OP_POP;
        else if (r >= 96)
            return (r[0]) ? OP_UNDEF7 : OP_UNDEF6;
        else
        begin
            op_pick = $urandom_range(rpnsc_pkg::OP_ADD, rpnsc_pkg::OP_DIV);
            return op_pick[rpnsc_pkg::OPC_W-1:0];
        end
    endfunction

    function automatic void add_row(logic [rpnsc_pkg::OPC_W-1:0] opc,
                                    logic [rpnsc_pkg::DATA_W-1:0] opnd, bit typed,
                                    logic [rpnsc_pkg::DATA_W-1:0] value, logic empty_flag,
                                    logic [rpnsc_pkg::STAT_W-1:0] status);
        dir_row_t row;
        row.opcode  = opc;
        row.operand = opnd;
        row.typed   = typed;
        row.want    = '{value, empty_flag, status};
        dir_rows.push_back(row);
    endfunction

    // Drive one transaction from a falling edge; returns at the falling edge after acceptance
    task automatic send_item(logic [rpnsc_pkg::OPC_W-1:0] opc,
                             logic [rpnsc_pkg::DATA_W-1:0] opnd, bit typed,
                             calc_result_t want);
        int           gap;
        calc_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= opc;
        s_axis_tdata  <= opnd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        res = calc_step(opc, opnd);
        pending_results.push_back(typed ? want : res);
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result sink backpressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end
        else if (no_idle || $urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b1;
        else
        begin
            stall_left = pick_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        calc_result_t want;
        calc_result_t got;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[3:1]};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: value=%h empty=%b status=%0d",
                             got.value, got.empty_flag, got.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value || got.empty_flag !== want.empty_flag
                    || got.status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: expected value=%h empty=%b status=%0d,",
                                  " got value=%h empty=%b status=%0d"},
                                 want.value, want.empty_flag, want.status,
                                 got.value, got.empty_flag, got.status);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int                          n_random;
        int                          mode;
        int                          phase_len;
        logic [rpnsc_pkg::OPC_W-1:0] opc;
        calc_result_t                none;
        none = '0;
        n_random = 0;

        // Directed sequence: empty-stack errors, extremes, divide by zero, undefined opcodes
        add_row(rpnsc_pkg::OP_POP,  32'h0,         1, rpnsc_pkg::POP_EMPTY_VALUE, 1'b1,
                rpnsc_pkg::ST_EMPTY);
        add_row(rpnsc_pkg::OP_ADD,  32'h0,         1, 32'h0,         1'b1, rpnsc_pkg::ST_FEW);
        add_row(rpnsc_pkg::OP_PUSH, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_SUB,  32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0, rpnsc_pkg::ST_FEW);
        add_row(rpnsc_pkg::OP_PUSH, 32'h8000_0000, 1, 32'h8000_0000, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_ADD,  32'h1234_5678, 1, 32'hFFFF_FFFF, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'd5,         1, 32'd5,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'd0,         1, 32'd0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_DIV,  32'h0,         1, 32'd0,         1'b0,
                rpnsc_pkg::ST_DIVZERO);
        add_row(rpnsc_pkg::OP_POP,  32'h0,         1, 32'd0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_DIV,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'd3,         1, 32'd3,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_MUL,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'd7,         1, 32'd7,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_SUB,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(OP_UNDEF6,          32'hFFFF_FFFF, 0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(OP_UNDEF7,          32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'h8000_0000, 1, 32'h8000_0000, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_SUB,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_PUSH, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_MUL,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_POP,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_POP,  32'h0,         0, 32'h0,         1'b0, rpnsc_pkg::ST_OK);
        add_row(rpnsc_pkg::OP_POP,  32'h0,         1, rpnsc_pkg::POP_EMPTY_VALUE, 1'b1,
                rpnsc_pkg::ST_EMPTY);

        // Reset
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].opcode, dir_rows[i].operand, dir_rows[i].typed,
                      dir_rows[i].want);

        // Hold the sender until the block has delivered everything
        wait_results_drained();

        // Random phases: mixed traffic, fills past full, drains past empty
        while (n_random < N_RANDOM)
        begin
            mode      = $urandom_range(MODE_MIXED, MODE_DRAIN);
            phase_len = (mode == MODE_FILL) ? $urandom_range(70, 90) : $urandom_range(20, 60);
            if (phase_len > N_RANDOM - n_random)
                phase_len = N_RANDOM - n_random;
            no_idle   = ($urandom_range(0, 5) == 0);
            repeat (phase_len)
            begin
                opc = pick_opcode(mode);
                send_item(opc, pick_operand(), 1'b0, none);
                n_random++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_results_drained();
        end
        no_idle = 1'b0;

        // Drain and let any stray result show up
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
